/* design/stpl_pkg.sv */
// Shared constants and types for the segmented trie prefix lookup unit.
package stpl_pkg;
    localparam int SegBits  = 16;
    localparam int NodeBits = 16;
    localparam int HopBits  = 8;
    localparam int TrieDepth = 32 - SegBits;
    localparam int DirDepth = 1 << SegBits;
    localparam int NodeCount = 1 << NodeBits;
    localparam int SrWidth  = 1 + 5 + HopBits;
    localparam int PortWidth = 1 + HopBits;
    localparam int ChildWidth = 2 * NodeBits;

    localparam logic OpInsert = 1'b0;
    localparam logic OpLookup = 1'b1;

    // Command bundle from controller to datapath.
    typedef struct packed {
        logic load;         // capture the input item
        logic clr_rd;       // address the directory at the sweep address for the clearing pass
        logic clr_wr;       // write clearing entries at the sweep address
        logic dir_rd;       // read directory at the segment
        logic sr_rd;        // read short-route entry at the sweep address
        logic sr_wr;        // conditionally write the read short-route entry
        logic sweep_init;   // load sweep address from the prefix segment
        logic sweep_inc;    // step sweep address
        logic node_rd;      // read node at the current node
        logic walk_step;    // descend along the address bit
        logic alloc_root;   // allocate a root node
        logic alloc_child;  // allocate a child node
        logic mark;         // mark the current node if unmarked
        logic res_lookup;   // build a lookup result
        logic res_insert;   // build an insert result
        logic status_full;  // insert result carries full status
    } t_cmd;

    typedef struct packed {
        logic op;
        logic is_short;
        logic sweep_last;
        logic clr_last;
        logic root_zero;
        logic child_zero;
        logic walk_done;
        logic store_full;
    } t_stat;
endpackage

/* design/stpl_ram.sv */
// Generic single-port RAM with registered read.
module stpl_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* design/stpl_datapath.sv */
// Datapath: item registers, directory, short routes, node store and result.
module stpl_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  stpl_pkg::t_cmd               i_cmd,
    output stpl_pkg::t_stat              o_stat,
    input  logic                         i_operation,
    input  logic [31:0]                  i_address,
    input  logic [5:0]                   i_prefix_len,
    input  logic [7:0]                   i_next_hop,
    output logic                         o_hit,
    output logic [7:0]                   o_result_hop,
    output logic                         o_status
);
    localparam int SB = stpl_pkg::SegBits;
    localparam int NB = stpl_pkg::NodeBits;
    localparam int HB = stpl_pkg::HopBits;

    logic            r_op;
    logic [31:0]     r_addr;
    logic [5:0]      r_len;
    logic [HB-1:0]   r_hop;
    logic [SB-1:0]   r_sweep;
    logic [SB-1:0]   r_span_mask;
    logic [NB-1:0]   r_cur;
    logic [4:0]      r_depth;
    logic [NB:0]     r_free;
    logic            r_found;
    logic [HB-1:0]   r_best;
    logic            r_hit;
    logic [HB-1:0]   r_res_hop;
    logic            r_status;

    logic [5:0]      n_len;
    logic [31:0]     n_mask;
    logic [SB-1:0]   seg;
    logic            bit_now;

    logic            dir_we;
    logic [SB-1:0]   dir_addr;
    logic [NB-1:0]   dir_wdata, dir_rdata;
    logic            sr_we;
    logic [SB-1:0]   sr_addr;
    logic [stpl_pkg::SrWidth-1:0] sr_wdata, sr_rdata;
    logic            ch_we;
    logic [NB-1:0]   ch_addr;
    logic [stpl_pkg::ChildWidth-1:0] ch_wdata, ch_rdata;
    logic            pt_we;
    logic [stpl_pkg::PortWidth-1:0] pt_wdata, pt_rdata;
    logic [NB-1:0]   child;
    logic [NB-1:0]   new_node;

    assign n_len  = (i_prefix_len > 6'd32) ? 6'd32 : i_prefix_len;
    assign n_mask = (n_len == 6'd0) ? 32'd0 : (32'hFFFF_FFFF << (6'd32 - n_len));
    assign seg    = r_addr[31 -: SB];
    assign bit_now = r_addr[31 - SB - r_depth[3:0]];
    assign child  = bit_now ? ch_rdata[NB-1:0] : ch_rdata[2*NB-1:NB];
    assign new_node = r_free[NB-1:0];

    // Directory: cleared by the controller sweep, written on root allocation.
    assign dir_we    = i_cmd.clr_wr | i_cmd.alloc_root;
    assign dir_addr  = (i_cmd.clr_wr | i_cmd.clr_rd) ? r_sweep : seg;
    assign dir_wdata = i_cmd.clr_wr ? '0 : new_node;

    // A lookup reads the short route of its own segment; inserts use the sweep address.
    assign sr_addr = (i_cmd.clr_wr || r_op != stpl_pkg::OpLookup) ? r_sweep : seg;

    // The short-route entry is replaced when invalid or not longer than the new one.
    assign sr_we = i_cmd.clr_wr | (i_cmd.sr_wr &
        (!sr_rdata[stpl_pkg::SrWidth-1] || (r_len[4:0] >= sr_rdata[HB+4:HB])));
    assign sr_wdata = i_cmd.clr_wr ? '0 : {1'b1, r_len[4:0], r_hop};

    // The clearing pass zeroes every node, so a node is clean when it is allocated.
    assign ch_addr = i_cmd.clr_wr ? r_sweep : r_cur;
    always_comb begin
        ch_we    = 1'b0;
        ch_wdata = ch_rdata;
        pt_we    = 1'b0;
        pt_wdata = pt_rdata;
        if (i_cmd.clr_wr) begin
            ch_we    = 1'b1;
            ch_wdata = '0;
            pt_we    = 1'b1;
            pt_wdata = '0;
        end
        if (i_cmd.alloc_child) begin
            ch_we = 1'b1;
            if (bit_now) begin
                ch_wdata = {ch_rdata[2*NB-1:NB], new_node};
            end else begin
                ch_wdata = {new_node, ch_rdata[NB-1:0]};
            end
        end
        if (i_cmd.mark && !pt_rdata[HB]) begin
            pt_we    = 1'b1;
            pt_wdata = {1'b1, r_hop};
        end
    end

    stpl_ram #(.Width(NB), .Depth(stpl_pkg::DirDepth)) u_dir (
        .i_clk(i_clk), .i_we(dir_we), .i_addr(dir_addr),
        .i_wdata(dir_wdata), .o_rdata(dir_rdata));
    stpl_ram #(.Width(stpl_pkg::SrWidth), .Depth(stpl_pkg::DirDepth)) u_sr (
        .i_clk(i_clk), .i_we(sr_we), .i_addr(sr_addr),
        .i_wdata(sr_wdata), .o_rdata(sr_rdata));
    stpl_ram #(.Width(stpl_pkg::ChildWidth), .Depth(stpl_pkg::NodeCount)) u_child (
        .i_clk(i_clk), .i_we(ch_we), .i_addr(ch_addr),
        .i_wdata(ch_wdata), .o_rdata(ch_rdata));
    stpl_ram #(.Width(stpl_pkg::PortWidth), .Depth(stpl_pkg::NodeCount)) u_port (
        .i_clk(i_clk), .i_we(pt_we), .i_addr(ch_addr),
        .i_wdata(pt_wdata), .o_rdata(pt_rdata));

    assign o_stat.op         = r_op;
    assign o_stat.is_short   = (r_len <= 6'(SB));
    assign o_stat.sweep_last = ((r_sweep & r_span_mask) == r_span_mask);
    assign o_stat.clr_last   = (r_sweep == '1);
    assign o_stat.root_zero  = (dir_rdata == '0);
    assign o_stat.child_zero = (child == '0);
    assign o_stat.walk_done  = (r_op == stpl_pkg::OpLookup) ?
        (r_depth == 5'(stpl_pkg::TrieDepth)) : ({1'b0, r_depth} == r_len - 6'(SB));
    assign o_stat.store_full = (r_free == (NB+1)'(stpl_pkg::NodeCount));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free     <= (NB+1)'(1);
            r_sweep    <= '0;
        end else begin
            if (i_cmd.clr_wr || i_cmd.sweep_inc) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (i_cmd.sweep_init) begin
                r_sweep <= seg & ~r_span_mask;
            end
            if (i_cmd.alloc_root || i_cmd.alloc_child) begin
                r_free <= r_free + 1'b1;
            end
        end
        if (i_cmd.load) begin
            r_op   <= i_operation;
            r_addr <= (i_operation == stpl_pkg::OpLookup) ? i_address : (i_address & n_mask);
            r_len  <= n_len;
            r_hop  <= i_next_hop[HB-1:0];
            r_span_mask <= SB'((SB+1)'(1) << (6'(SB) - ((n_len > 6'(SB)) ? 6'(SB) : n_len))) - 1'b1;
            r_found <= 1'b0;
            r_depth <= '0;
        end
        if (i_cmd.dir_rd) begin
            r_cur <= dir_rdata;
            r_depth <= '0;
        end
        if (i_cmd.alloc_root) begin
            r_cur <= new_node;
        end
        if (i_cmd.walk_step) begin
            if (i_cmd.alloc_child) begin
                r_cur <= new_node;
            end else begin
                r_cur <= child;
            end
            r_depth <= r_depth + 1'b1;
        end
        if (i_cmd.node_rd && r_cur != '0 && pt_rdata[HB]) begin
            r_found <= 1'b1;
            r_best  <= pt_rdata[HB-1:0];
        end
        if (i_cmd.res_lookup) begin
            r_hit     <= r_found | sr_rdata[stpl_pkg::SrWidth-1];
            r_res_hop <= r_found ? r_best :
                (sr_rdata[stpl_pkg::SrWidth-1] ? sr_rdata[HB-1:0] : '0);
            r_status  <= 1'b0;
        end
        if (i_cmd.res_insert) begin
            r_hit     <= 1'b0;
            r_res_hop <= '0;
            r_status  <= i_cmd.status_full;
        end
    end

    assign o_hit        = r_hit;
    assign o_result_hop = 8'(r_res_hop);
    assign o_status     = r_status;
endmodule

/* design/stpl_ctrl.sv */
// Controller state machine sequencing the clearing pass, inserts and lookups.
module stpl_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  stpl_pkg::t_stat i_stat,
    output stpl_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_done
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DIR, S_DIRW, S_SR_RD, S_SR_WAIT, S_SR_WR,
        S_ROOT, S_NODE_RD, S_NODE_WAIT, S_NODE, S_MARK_RD, S_MARK_WAIT,
        S_MARK, S_LK_SR, S_LK_RES
    } t_state;

    t_state r_state;
    logic   r_done;
    logic   r_node_new;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_CLEAR:  o_cmd.clr_wr = 1'b1;
            S_IDLE:   o_cmd.load = i_start;
            S_DIR:    ;
            S_DIRW: begin
                if (i_stat.op == stpl_pkg::OpLookup) begin
                    o_cmd.dir_rd = 1'b1;
                end else if (i_stat.is_short) begin
                    o_cmd.sweep_init = 1'b1;
                end else if (i_stat.root_zero) begin
                    if (i_stat.store_full) begin
                        o_cmd.res_insert  = 1'b1;
                        o_cmd.status_full = 1'b1;
                    end else begin
                        o_cmd.alloc_root = 1'b1;
                    end
                end else begin
                    o_cmd.dir_rd = 1'b1;
                end
            end
            S_SR_RD, S_SR_WAIT: ;
            S_SR_WR: begin
                o_cmd.sr_wr = 1'b1;
                if (i_stat.sweep_last) begin
                    o_cmd.res_insert = 1'b1;
                end else begin
                    o_cmd.sweep_inc = 1'b1;
                end
            end
            S_ROOT: ;
            S_NODE_RD, S_NODE_WAIT: ;
            S_NODE: begin
                o_cmd.node_rd = (i_stat.op == stpl_pkg::OpLookup);
                if (i_stat.op == stpl_pkg::OpLookup) begin
                    if (!i_stat.walk_done && !i_stat.child_zero) begin
                        o_cmd.walk_step = 1'b1;
                    end
                end else if (!i_stat.walk_done) begin
                    if (!i_stat.child_zero && !r_node_new) begin
                        o_cmd.walk_step = 1'b1;
                    end else if (i_stat.store_full) begin
                        o_cmd.res_insert  = 1'b1;
                        o_cmd.status_full = 1'b1;
                    end else begin
                        o_cmd.walk_step   = 1'b1;
                        o_cmd.alloc_child = 1'b1;
                    end
                end
            end
            S_MARK_RD, S_MARK_WAIT: ;
            S_MARK: begin
                o_cmd.mark = 1'b1;
                o_cmd.res_insert = 1'b1;
            end
            S_LK_SR: ;
            S_LK_RES: o_cmd.res_lookup = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_done     <= 1'b0;
            r_node_new <= 1'b0;
        end else begin
            r_done <= o_cmd.res_insert | o_cmd.res_lookup;
            case (r_state)
                S_CLEAR: if (i_stat.clr_last) r_state <= S_IDLE;
                S_IDLE:  if (i_start) r_state <= S_DIR;
                S_DIR:   r_state <= S_DIRW;
                S_DIRW: begin
                    r_node_new <= 1'b0;
                    if (i_stat.op == stpl_pkg::OpLookup) begin
                        r_state <= S_NODE_RD;
                    end else if (i_stat.is_short) begin
                        r_state <= S_SR_RD;
                    end else if (i_stat.root_zero) begin
                        r_node_new <= 1'b1;
                        r_state <= i_stat.store_full ? S_IDLE : S_NODE_RD;
                    end else begin
                        r_state <= S_NODE_RD;
                    end
                end
                S_SR_RD:   r_state <= S_SR_WAIT;
                S_SR_WAIT: r_state <= S_SR_WR;
                S_SR_WR:   r_state <= i_stat.sweep_last ? S_IDLE : S_SR_RD;
                S_NODE_RD:   r_state <= S_NODE_WAIT;
                S_NODE_WAIT: r_state <= S_NODE;
                S_NODE: begin
                    if (i_stat.op == stpl_pkg::OpLookup) begin
                        r_state <= (i_stat.walk_done || i_stat.child_zero) ?
                            S_LK_SR : S_NODE_RD;
                    end else if (i_stat.walk_done) begin
                        r_state <= S_MARK;
                    end else if ((i_stat.child_zero || r_node_new) && i_stat.store_full) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_node_new <= i_stat.child_zero || r_node_new;
                        r_state <= S_NODE_RD;
                    end
                end
                S_MARK:   r_state <= S_IDLE;
                S_LK_SR:  r_state <= S_LK_RES;
                S_LK_RES: r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
endmodule

/* design/segmented_trie_prefix_lookup_unit.sv */
// Top level of the segmented trie longest-prefix-match unit.
// Usage: drive i_operation, i_address, i_prefix_len and i_next_hop and raise
// start while busy is low; the item transfers at that clock edge.
// One result per item appears on o_hit, o_result_hop and o_status for exactly
// one cycle, marked by o_valid; the receiver cannot hold it off.
// A lookup visits 1 to 17 trie nodes. A trie insert walks prefix length - 15
// nodes, or fewer when the node store runs full. A short-route insert reads and
// conditionally writes each covered short-route entry in turn, one for a 16-bit
// prefix and 65536 for a zero-length one. The strobe is high in the cycle in
// which busy falls, and the next item may transfer in that cycle. The state
// sequences wait on the registered reads of the single-port memories.
// After reset the unit clears all 65536 entries of the directory, short-route
// and node tables, one entry a cycle, with busy high before the first item
// transfers.
module segmented_trie_prefix_lookup_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_operation,
    input  logic [31:0] i_address,
    input  logic [5:0]  i_prefix_len,
    input  logic [7:0]  i_next_hop,
    output logic        o_valid,
    output logic        o_hit,
    output logic [7:0]  o_result_hop,
    output logic        o_status
);
    stpl_pkg::t_cmd  cmd;
    stpl_pkg::t_stat stat;

    stpl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_stat(stat),
        .o_cmd(cmd), .o_busy(busy), .o_done(o_valid));

    stpl_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_operation(i_operation), .i_address(i_address),
        .i_prefix_len(i_prefix_len), .i_next_hop(i_next_hop),
        .o_hit(o_hit), .o_result_hop(o_result_hop), .o_status(o_status));

`ifndef ASSERT_OFF
    a_no_valid_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid) else $error("result strobe right after reset");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("unit not busy after a transfer");
    a_miss_zero_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_result_hop == 8'd0) else $error("hop on a miss");
    a_hit_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_hit |-> !o_status) else $error("status set on a hit");
`endif
endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the segmented trie longest-prefix-match unit.
module tb_top;
    typedef struct packed {
        logic        op;
        logic [31:0] addr;
        logic [5:0]  len;
        logic [7:0]  hop;
    } t_route_cmd;

    typedef struct packed {
        logic       hit;
        logic [7:0] hop;
        logic       status;
    } t_route_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_operation = stpl_pkg::OpLookup;
    logic [31:0] i_address = '0;
    logic [5:0]  i_prefix_len = '0;
    logic [7:0]  i_next_hop = '0;
    logic        o_valid;
    logic        o_hit;
    logic [7:0]  o_result_hop;
    logic        o_status;

    segmented_trie_prefix_lookup_unit uut (.*);

    always #1 i_clk = ~i_clk;

    // Shadow copy of the route tables.
    int unsigned seg_root   [stpl_pkg::DirDepth];
    bit          sr_valid   [stpl_pkg::DirDepth];
    int unsigned sr_len     [stpl_pkg::DirDepth];
    logic [7:0]  sr_hop     [stpl_pkg::DirDepth];
    int unsigned kid_left   [stpl_pkg::NodeCount];
    int unsigned kid_right  [stpl_pkg::NodeCount];
    bit          port_valid [stpl_pkg::NodeCount];
    logic [7:0]  port_hop   [stpl_pkg::NodeCount];
    int unsigned next_free;

    t_route_cmd  pending_cmds[$];
    t_route_resp expected_resps[$];
    logic [31:0] known_prefixes[$];
    int unsigned seg_pool[$];
    int          errors = 0;
    longint      cycle_count = 0;

    function automatic int unsigned grab_node();
        int unsigned n;
        if (next_free >= stpl_pkg::NodeCount) return 0;
        n = next_free;
        next_free++;
        kid_left[n] = 0;
        kid_right[n] = 0;
        port_valid[n] = 1'b0;
        return n;
    endfunction

    function automatic t_route_resp route_predict(t_route_cmd c);
        t_route_resp r;
        int unsigned len, seg, span, base, cur, child, b;
        logic [31:0] a;
        r = '0;
        if (c.op == stpl_pkg::OpInsert) begin
            len = (c.len > 32) ? 32 : c.len;
            a = (len == 0) ? 32'd0 : (c.addr & (32'hFFFF_FFFF << (32 - len)));
            seg = a >> stpl_pkg::TrieDepth;
            if (len <= stpl_pkg::SegBits) begin
                span = 1 << (stpl_pkg::SegBits - len);
                base = seg & ~(span - 1);
                for (int k = 0; k < span; k++) begin
                    if (!sr_valid[base + k] || len >= sr_len[base + k]) begin
                        sr_valid[base + k] = 1'b1;
                        sr_len[base + k] = len;
                        sr_hop[base + k] = c.hop;
                    end
                end
                return r;
            end
            cur = seg_root[seg];
            if (cur == 0) begin
                cur = grab_node();
                if (cur == 0) begin
                    r.status = 1'b1;
                    return r;
                end
                seg_root[seg] = cur;
            end
            for (int i = 0; i < len - stpl_pkg::SegBits; i++) begin
                b = a[31 - stpl_pkg::SegBits - i];
                child = b ? kid_right[cur] : kid_left[cur];
                if (child == 0) begin
                    child = grab_node();
                    if (child == 0) begin
                        r.status = 1'b1;
                        return r;
                    end
                    if (b) kid_right[cur] = child;
                    else kid_left[cur] = child;
                end
                cur = child;
            end
            if (!port_valid[cur]) begin
                port_valid[cur] = 1'b1;
                port_hop[cur] = c.hop;
            end
        end else begin
            seg = c.addr >> stpl_pkg::TrieDepth;
            cur = seg_root[seg];
            if (cur != 0 && port_valid[cur]) begin
                r.hit = 1'b1;
                r.hop = port_hop[cur];
            end
            for (int i = 0; i < stpl_pkg::TrieDepth && cur != 0; i++) begin
                cur = c.addr[31 - stpl_pkg::SegBits - i] ? kid_right[cur] : kid_left[cur];
                if (cur != 0 && port_valid[cur]) begin
                    r.hit = 1'b1;
                    r.hop = port_hop[cur];
                end
            end
            if (!r.hit && sr_valid[seg]) begin
                r.hit = 1'b1;
                r.hop = sr_hop[seg];
            end
        end
        return r;
    endfunction

    function automatic t_route_cmd mk_cmd(logic op, logic [31:0] a, logic [5:0] l,
                                          logic [7:0] h);
        t_route_cmd c;
        c.op = op;
        c.addr = a;
        c.len = l;
        c.hop = h;
        return c;
    endfunction

    // Driver: one start assignment per edge, next item raised after a random gap that follows each transfer.
    t_route_cmd cur_cmd;
    int         gap_left = 0;
    logic       start_nxt;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            start_nxt = start;
            if (start && !busy) begin
                expected_resps.push_back(route_predict(cur_cmd));
                gap_left = $urandom_range(0, 5);
                start_nxt = 1'b0;
            end
            if (!start_nxt) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    i_operation <= cur_cmd.op;
                    i_address <= cur_cmd.addr;
                    i_prefix_len <= cur_cmd.len;
                    i_next_hop <= cur_cmd.hop;
                    start_nxt = 1'b1;
                end
            end
            start <= start_nxt;
        end
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    t_route_resp want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_resps.size() == 0) begin
                $display("%0t: unexpected result hit=%b hop=%0d status=%b",
                         $time, o_hit, o_result_hop, o_status);
                errors++;
            end else begin
                want = expected_resps.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit expected %b actual %b", $time, want.hit, o_hit);
                    errors++;
                end
                if (o_result_hop !== want.hop) begin
                    $display("%0t: result_hop expected %0d actual %0d",
                             $time, want.hop, o_result_hop);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status expected %b actual %b",
                             $time, want.status, o_status);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > 3000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] pool_addr();
        return {seg_pool[$urandom_range(0, seg_pool.size() - 1)][15:0], 16'($urandom)};
    endfunction

    initial begin
        logic [31:0] a;
        int unsigned pick, l;
        foreach (seg_root[i]) begin
            seg_root[i] = 0;
            sr_valid[i] = 1'b0;
        end
        next_free = 1;
        for (int i = 0; i < 24; i++) seg_pool.push_back($urandom_range(0, 16'h7FFF));

        // Directed part: miss, default route, short-route priorities, trie corners.
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'h0000_0000, 6'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'hFFFF_FFFF, 6'd0, 8'd1));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'h1234_5678, 6'd63, 8'hFF));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'h0A00_0000, 6'd8, 8'd10));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'h0AFF_0000, 6'd16, 8'd20));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'h0A12_3456, 6'd8, 8'd11));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'h0AFF_FFFF, 6'd16, 8'd21));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'h0AFF_0001, 6'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'h0A01_0001, 6'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'hFFFF_FFFF, 6'd32, 8'hFF));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'hFFFF_FFFF, 6'd32, 8'd7));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'hFFFF_8000, 6'd17, 8'd17));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'hFFFF_FFFF, 6'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'hFFFF_8001, 6'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'hFFFF_0001, 6'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'h0000_0000, 6'd40, 8'd0));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'h0001_0001, 6'd63, 8'd33));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'h0000_0000, 6'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'h0001_0001, 6'd0, 8'd0));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, 32'h0AFF_FFFF, 6'd24, 8'd44));
        pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, 32'h0AFF_FF12, 6'd0, 8'd0));

        // Random part: mostly inserts and lookups around a small pool of segments.
        for (int n = 0; n < 1710; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                a = ($urandom_range(0, 9) < 8) ? pool_addr() : $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 75) l = $urandom_range(17, 32);
                else if (pick < 88) l = $urandom_range(12, 16);
                else if (pick < 96) l = $urandom_range(33, 63);
                else l = $urandom_range(8, 11);
                pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, a, 6'(l), 8'($urandom)));
                known_prefixes.push_back(a);
            end else begin
                if (known_prefixes.size() > 0 && pick < 85) begin
                    a = known_prefixes[$urandom_range(0, known_prefixes.size() - 1)];
                    a ^= $urandom & ((32'd1 << $urandom_range(0, 16)) - 1);
                end else begin
                    a = ($urandom_range(0, 1) != 0) ? pool_addr() : $urandom;
                end
                pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, a, 6'($urandom),
                                              8'($urandom)));
            end
        end

        // Full-length routes in fresh segments, each followed by lookups.
        for (int k = 0; k < 6; k++) begin
            a = {1'b1, 15'($urandom_range(3900, 16'h7FFF)), 16'($urandom)};
            pending_cmds.push_back(mk_cmd(stpl_pkg::OpInsert, a, 6'd32, 8'($urandom)));
            pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, a, 6'd0, 8'd0));
            pending_cmds.push_back(mk_cmd(stpl_pkg::OpLookup, {1'b1, 15'(k), 16'($urandom)},
                                          6'd0, 8'd0));
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk);
        while (pending_cmds.size() != 0 || start || expected_resps.size() != 0);
        repeat (100) @(posedge i_clk);
        if (errors == 0 && expected_resps.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
